// File: hw/rtl/wrm_pkg.sv
// Shared types, constants and the Gaussian weight ROM of the radar mosaic cell.
// Used by every module under hw/rtl except wrm_divstep; depends on nothing.
package wrm_pkg;

    // Field widths of the stream payloads
    localparam int CODE_W      = 8;
    localparam int OFFSET_W    = 10;
    localparam int CELL_W      = 16;
    localparam int RANGE_W     = 10;
    localparam int CNT_OUT_W   = 5;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    // Offsets at or above this saturate to one below it
    localparam int MAX_OFFSET  = 1024;

    // Weight ROM
    localparam int WEIGHT_BITS = 16;
    localparam int EXP_DEPTH   = 256;
    localparam int IDX_W       = 8;

    // Shared multiplier and range arithmetic
    localparam int MUL_W       = 26;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int R2_W        = PROD_W + 1;
    localparam int RS2_W       = 2 * RANGE_W;
    localparam int LIM_SHIFT   = 19;
    localparam int LIM_W       = RS2_W + LIM_SHIFT;

    // Mean division: quotient bits and step counter
    localparam int QUO_W       = 9;
    localparam int STEP_W      = 4;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_SCALE   = 3'd0,
        REG_CELL_WIDTH_X  = 3'd1,
        REG_CELL_WIDTH_Y  = 3'd2,
        REG_CODE_NO_OBS   = 3'd3,
        REG_CODE_INVALID  = 3'd4,
        REG_CODE_FOLDED   = 3'd5,
        REG_CODE_CLUTTER  = 3'd6
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [RANGE_W-1:0] RANGE_SCALE_RST  = 10'd50;
    localparam logic [CELL_W-1:0]  CELL_WIDTH_RST   = 16'd256;
    localparam logic [CODE_W-1:0]  CODE_NO_OBS_RST  = 8'd0;
    localparam logic [CODE_W-1:0]  CODE_INVALID_RST = 8'd1;
    localparam logic [CODE_W-1:0]  CODE_FOLDED_RST  = 8'd2;
    localparam logic [CODE_W-1:0]  CODE_CLUTTER_RST = 8'd3;

    typedef struct packed {
        logic [RANGE_W-1:0] range_scale_km;
        logic [CELL_W-1:0]  cell_width_x;
        logic [CELL_W-1:0]  cell_width_y;
        logic [CODE_W-1:0]  code_no_observation;
        logic [CODE_W-1:0]  code_invalid;
        logic [CODE_W-1:0]  code_range_folded;
        logic [CODE_W-1:0]  code_clutter;
    } cfg_t;

    typedef logic [WEIGHT_BITS-1:0] exp_rom_t [EXP_DEPTH];

    // exp(-8*i/depth) scaled to the weight range: Q31 Taylor series on x/256,
    // then eight rounded squarings, floored at one LSB
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] one_q31;
        logic [63:0] half_q31;
        logic [63:0] wmax;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] y4;
        logic [63:0] t;
        logic [63:0] w;
        one_q31  = 64'd1 << 31;
        half_q31 = 64'd1 << 30;
        wmax     = (64'd1 << WEIGHT_BITS) - 64'd1;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            x  = (64'(i) << 34) / 64'(EXP_DEPTH);
            y  = x >> 8;
            y2 = (y * y) >> 31;
            y3 = (y2 * y) >> 31;
            y4 = (y3 * y) >> 31;
            t  = one_q31 - y + y2 / 64'd2 - y3 / 64'd6 + y4 / 64'd24;
            if (t > one_q31) begin
                t = one_q31;
            end
            for (int k = 0; k < 8; k++) begin
                t = (t * t + half_q31) >> 31;
            end
            w = (t * wmax + half_q31) >> 31;
            if (w < 64'd1) begin
                w = 64'd1;
            end
            rom[i] = w[WEIGHT_BITS-1:0];
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// File: hw/rtl/wrm_cfg_regs.sv
// Configuration register file of the radar mosaic cell.
// Depends on wrm_pkg for the register indexes, reset values and cfg_t.
module wrm_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wrm_pkg::cfg_t                   cfg
);

    wrm_pkg::cfg_t cfg_reg;
    wrm_pkg::cfg_t cfg_next;

    // Take a write request in every cycle
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index; unknown indexes leave everything as is
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (wrm_pkg::cfg_reg_t'(cfg_index))
                wrm_pkg::REG_RANGE_SCALE: begin
                    cfg_next.range_scale_km = cfg_data[wrm_pkg::RANGE_W-1:0];
                end
                wrm_pkg::REG_CELL_WIDTH_X: begin
                    cfg_next.cell_width_x = cfg_data[wrm_pkg::CELL_W-1:0];
                end
                wrm_pkg::REG_CELL_WIDTH_Y: begin
                    cfg_next.cell_width_y = cfg_data[wrm_pkg::CELL_W-1:0];
                end
                wrm_pkg::REG_CODE_NO_OBS: begin
                    cfg_next.code_no_observation = cfg_data[wrm_pkg::CODE_W-1:0];
                end
                wrm_pkg::REG_CODE_INVALID: begin
                    cfg_next.code_invalid = cfg_data[wrm_pkg::CODE_W-1:0];
                end
                wrm_pkg::REG_CODE_FOLDED: begin
                    cfg_next.code_range_folded = cfg_data[wrm_pkg::CODE_W-1:0];
                end
                wrm_pkg::REG_CODE_CLUTTER: begin
                    cfg_next.code_clutter = cfg_data[wrm_pkg::CODE_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_scale_km      <= wrm_pkg::RANGE_SCALE_RST;
            cfg_reg.cell_width_x        <= wrm_pkg::CELL_WIDTH_RST;
            cfg_reg.cell_width_y        <= wrm_pkg::CELL_WIDTH_RST;
            cfg_reg.code_no_observation <= wrm_pkg::CODE_NO_OBS_RST;
            cfg_reg.code_invalid        <= wrm_pkg::CODE_INVALID_RST;
            cfg_reg.code_range_folded   <= wrm_pkg::CODE_FOLDED_RST;
            cfg_reg.code_clutter        <= wrm_pkg::CODE_CLUTTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/wrm_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on wrm_pkg for the operand and product widths.
module wrm_mul (
    input  logic                        aclk,
    input  logic [wrm_pkg::MUL_W-1:0]   mul_a,
    input  logic [wrm_pkg::MUL_W-1:0]   mul_b,
    output logic [wrm_pkg::PROD_W-1:0]  prod
);

    logic [wrm_pkg::PROD_W-1:0] prod_reg;

    // Register the product; the sequencer reads it in the following cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/wrm_divstep.sv
// Shared compare-and-subtract step for both long divisions of the cell.
// Stand-alone; the width comes from the instantiating module.
module wrm_divstep #(
    parameter int WIDTH = 40
) (
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             ge,
    output logic [WIDTH-1:0] diff
);

    logic borrow;

    // One subtract gives both the difference and the compare result
    assign {borrow, diff} = {1'b0, dividend} - {1'b0, divisor};
    assign ge = ~borrow;

endmodule

// File: hw/rtl/weighted_radar_mosaic_cell.sv
// A contribution with a valid code passes through the multiply steps on the shared
// multiplier, 8 restoring steps for the table index (skipped beyond the limit), ROM read
// and weight accumulate; any other contribution is taken in ST_IDLE alone. The last one
// adds 9 quotient steps for the mean if a site was counted, then waits in ST_DONE.
// A new request is taken only in ST_IDLE, once the previous one is through.
// Reset (aresetn, synchronous, active low) clears control, sums and flags and loads
// the default configuration at once; no clearing pass follows.
module weighted_radar_mosaic_cell #(
    parameter int MAX_SITES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input contributions
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wrm_pkg::S_TDATA_W-1:0]     s_tdata,  // site_code, offset_x, offset_y
    input  logic [0:0]                        s_tuser,  // kind
    input  logic                              s_tlast,  // last_site
    // Cell results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wrm_pkg::M_TDATA_W-1:0]     m_tdata,  // mosaic_code, valid_sites
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wrm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(MAX_SITES + 1);
    localparam int WSUM_W = wrm_pkg::WEIGHT_BITS + CNT_W;
    localparam int S_W    = WSUM_W + wrm_pkg::CODE_W;
    localparam int DIV_W  = (wrm_pkg::LIM_W + 1 > S_W + 2) ? wrm_pkg::LIM_W + 1 : S_W + 2;
    localparam int CODE_W = wrm_pkg::CODE_W;
    localparam int OFF_W  = wrm_pkg::OFFSET_W;
    localparam int MUL_W  = wrm_pkg::MUL_W;
    localparam int IDX_W  = wrm_pkg::IDX_W;
    localparam int QUO_W  = wrm_pkg::QUO_W;
    localparam int WB     = wrm_pkg::WEIGHT_BITS;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_MUL_X    = 15'b000000000000010,
        ST_MUL_Y    = 15'b000000000000100,
        ST_SQ_X     = 15'b000000000001000,
        ST_SQ_Y     = 15'b000000000010000,
        ST_SQ_R     = 15'b000000000100000,
        ST_LIM      = 15'b000000001000000,
        ST_CHECK    = 15'b000000010000000,
        ST_DIV_IDX  = 15'b000000100000000,
        ST_ROM      = 15'b000001000000000,
        ST_ACC_MUL  = 15'b000010000000000,
        ST_ACC_ADD  = 15'b000100000000000,
        ST_FINAL    = 15'b001000000000000,
        ST_DIV_MEAN = 15'b010000000000000,
        ST_DONE     = 15'b100000000000000
    } state_t;

    wrm_pkg::cfg_t cfg;

    // Control and accumulator registers
    state_t                  state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    logic [S_W-1:0]          wsum_code_reg, wsum_code_next;
    logic [WSUM_W-1:0]       wsum_reg, wsum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    observed_reg, observed_next;
    logic                    clutter_reg, clutter_next;
    logic                    folded_reg, folded_next;

    // Payload registers
    logic [CODE_W-1:0]               code_reg, code_next;
    logic [OFF_W-1:0]                ox_reg, ox_next;
    logic [OFF_W-1:0]                oy_reg, oy_next;
    logic                            last_reg, last_next;
    logic [MUL_W-1:0]                dx_reg, dx_next;
    logic [MUL_W-1:0]                dy_reg, dy_next;
    logic [wrm_pkg::R2_W-1:0]        r2_reg, r2_next;
    logic [wrm_pkg::LIM_W-1:0]       lim_reg, lim_next;
    logic [DIV_W-1:0]                rem_reg, rem_next;
    logic [DIV_W-1:0]                dsh_reg, dsh_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [QUO_W-1:0]                quo_reg, quo_next;
    logic [wrm_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [WB-1:0]                   w_reg, w_next;
    logic [CODE_W-1:0]               res_code_reg, res_code_next;
    logic [wrm_pkg::CNT_OUT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic [wrm_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Shared units
    logic [MUL_W-1:0]            mul_a, mul_b;
    logic [wrm_pkg::PROD_W-1:0]  prod;
    logic [DIV_W-1:0]            div_a, div_b, div_diff;
    logic                        div_ge;

    // Request decode
    logic                        s_fire;
    logic [CODE_W-1:0]           in_code;
    logic [OFF_W-1:0]            in_ox, in_oy;
    logic [RANGE_W_LOC-1:0]      rs_eff;
    logic [wrm_pkg::CNT_OUT_W-1:0] cnt_sat;
    logic [QUO_W-1:0]            quo_last;

    localparam int RANGE_W_LOC = wrm_pkg::RANGE_W;

    wrm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wrm_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    wrm_divstep #(
        .WIDTH (DIV_W)
    ) u_divstep (
        .dividend (div_a),
        .divisor  (div_b),
        .ge       (div_ge),
        .diff     (div_diff)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Unpack the request and saturate the offsets
    always_comb begin
        in_code = s_tdata[CODE_W-1:0];
        in_ox   = s_tdata[CODE_W +: OFF_W];
        in_oy   = s_tdata[CODE_W + OFF_W +: OFF_W];
        if ({1'b0, in_ox} >= (OFF_W + 1)'(wrm_pkg::MAX_OFFSET)) begin
            in_ox = OFF_W'(wrm_pkg::MAX_OFFSET - 1);
        end
        if ({1'b0, in_oy} >= (OFF_W + 1)'(wrm_pkg::MAX_OFFSET)) begin
            in_oy = OFF_W'(wrm_pkg::MAX_OFFSET - 1);
        end
    end

    // A zero range scale counts as one
    assign rs_eff = (cfg.range_scale_km == '0) ? RANGE_W_LOC'(1) : cfg.range_scale_km;

    // Valid-site count clipped to the output field
    assign cnt_sat = (32'(cnt_reg) > 32'd31) ? 5'd31 : wrm_pkg::CNT_OUT_W'(cnt_reg);

    assign quo_last = {quo_reg[QUO_W-2:0], div_ge};

    // Select the multiplier operands for each step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_X: begin
                mul_a = MUL_W'(ox_reg);
                mul_b = MUL_W'(cfg.cell_width_x);
            end
            ST_MUL_Y: begin
                mul_a = MUL_W'(oy_reg);
                mul_b = MUL_W'(cfg.cell_width_y);
            end
            ST_SQ_X: begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            ST_SQ_Y: begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            ST_SQ_R: begin
                mul_a = MUL_W'(rs_eff);
                mul_b = MUL_W'(rs_eff);
            end
            ST_ACC_MUL: begin
                mul_a = MUL_W'(w_reg);
                mul_b = MUL_W'(code_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Select the divider operands: fraction bits of r2/lim, or quotient bits of the mean
    always_comb begin
        if (state_reg == ST_DIV_MEAN) begin
            div_a = rem_reg;
            div_b = dsh_reg;
        end else begin
            div_a = {rem_reg[DIV_W-2:0], 1'b0};
            div_b = DIV_W'(lim_reg);
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        wsum_code_next = wsum_code_reg;
        wsum_next      = wsum_reg;
        cnt_next       = cnt_reg;
        observed_next  = observed_reg;
        clutter_next   = clutter_reg;
        folded_next    = folded_reg;
        code_next      = code_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        last_next      = last_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        r2_next        = r2_reg;
        lim_next       = lim_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        idx_next       = idx_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        w_next         = w_reg;
        res_code_next  = res_code_reg;
        res_cnt_next   = res_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    code_next = in_code;
                    ox_next   = in_ox;
                    oy_next   = in_oy;
                    last_next = s_tlast;
                    if (s_tuser[0]) begin
                        // Uncovered cell: report at once, drop the partial sums
                        res_code_next = cfg.code_no_observation;
                        res_cnt_next  = '0;
                        state_next    = ST_DONE;
                    end else begin
                        if (in_code != cfg.code_no_observation) begin
                            observed_next = 1'b1;
                        end
                        // Classify the code, first match wins
                        priority if (in_code > cfg.code_clutter) begin
                            folded_next = folded_reg;
                        end else if (in_code == cfg.code_invalid) begin
                            folded_next = folded_reg;
                        end else if (in_code == cfg.code_range_folded) begin
                            folded_next = 1'b1;
                        end else if (in_code == cfg.code_no_observation) begin
                            folded_next = folded_reg;
                        end else if (in_code == cfg.code_clutter) begin
                            clutter_next = 1'b1;
                        end else begin
                            folded_next = folded_reg;
                        end
                        if ((in_code > cfg.code_clutter) &&
                            (cnt_reg < CNT_W'(MAX_SITES))) begin
                            state_next = ST_MUL_X;
                        end else if (s_tlast) begin
                            state_next = ST_FINAL;
                        end
                    end
                end
            end
            ST_MUL_X: begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                dx_next    = prod[MUL_W-1:0];
                state_next = ST_SQ_X;
            end
            ST_SQ_X: begin
                dy_next    = prod[MUL_W-1:0];
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                r2_next    = wrm_pkg::R2_W'(prod);
                state_next = ST_SQ_R;
            end
            ST_SQ_R: begin
                r2_next    = r2_reg + wrm_pkg::R2_W'(prod);
                state_next = ST_LIM;
            end
            ST_LIM: begin
                lim_next   = {prod[wrm_pkg::RS2_W-1:0], {wrm_pkg::LIM_SHIFT{1'b0}}};
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // Once r2 reaches lim, the end of the weight table, the weight is one LSB
                if (r2_reg >= wrm_pkg::R2_W'(lim_reg)) begin
                    w_next     = WB'(1);
                    state_next = ST_ACC_MUL;
                end else begin
                    rem_next   = DIV_W'(r2_reg[wrm_pkg::LIM_W-1:0]);
                    idx_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_IDX;
                end
            end
            ST_DIV_IDX: begin
                rem_next  = div_ge ? div_diff : div_a;
                idx_next  = {idx_reg[IDX_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == wrm_pkg::STEP_W'(IDX_W - 1)) begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM: begin
                w_next     = wrm_pkg::EXP_ROM[idx_reg];
                state_next = ST_ACC_MUL;
            end
            ST_ACC_MUL: begin
                state_next = ST_ACC_ADD;
            end
            ST_ACC_ADD: begin
                wsum_code_next = wsum_code_reg + S_W'(prod[WB + CODE_W - 1:0]);
                wsum_next      = wsum_reg + WSUM_W'(w_reg);
                cnt_next       = cnt_reg + 1'b1;
                state_next     = last_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                res_cnt_next = cnt_sat;
                if (cnt_reg != '0) begin
                    // Rounded mean: (2*sum(w*code) + sum(w)) / (2*sum(w))
                    rem_next   = DIV_W'({wsum_code_reg, 1'b0}) + DIV_W'(wsum_reg);
                    dsh_next   = DIV_W'({wsum_reg, 1'b0, {(QUO_W - 1){1'b0}}});
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_MEAN;
                end else begin
                    priority if (!observed_reg) begin
                        res_code_next = cfg.code_no_observation;
                    end else if (clutter_reg) begin
                        res_code_next = cfg.code_clutter;
                    end else if (folded_reg) begin
                        res_code_next = cfg.code_range_folded;
                    end else begin
                        res_code_next = cfg.code_invalid;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DIV_MEAN: begin
                rem_next  = div_ge ? div_diff : rem_reg;
                dsh_next  = dsh_reg >> 1;
                quo_next  = quo_last;
                step_next = step_reg + 1'b1;
                if (step_reg == wrm_pkg::STEP_W'(QUO_W - 1)) begin
                    res_code_next = quo_last[QUO_W-1] ? {CODE_W{1'b1}}
                                                      : quo_last[CODE_W-1:0];
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free, then clear the cell
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = wrm_pkg::M_TDATA_W'({res_cnt_reg, res_code_reg});
                    wsum_code_next = '0;
                    wsum_next      = '0;
                    cnt_next       = '0;
                    observed_next  = 1'b0;
                    clutter_next   = 1'b0;
                    folded_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            wsum_code_reg <= '0;
            wsum_reg      <= '0;
            cnt_reg       <= '0;
            observed_reg  <= 1'b0;
            clutter_reg   <= 1'b0;
            folded_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            wsum_code_reg <= wsum_code_next;
            wsum_reg      <= wsum_next;
            cnt_reg       <= cnt_next;
            observed_reg  <= observed_next;
            clutter_reg   <= clutter_next;
            folded_reg    <= folded_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        last_reg     <= last_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        r2_reg       <= r2_next;
        lim_reg      <= lim_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        idx_reg      <= idx_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        w_reg        <= w_next;
        res_code_reg <= res_code_next;
        res_cnt_reg  <= res_cnt_next;
        m_data_reg   <= m_data_next;
    end

endmodule
